// ===== design/ray_march_box_probe_core_macros.svh =====
// ---------------------------------------------------------------------------
// Ray march box probe - assertion macros
// Shared concurrent assertion shorthands; both sample on clk, gated by rst.
// ---------------------------------------------------------------------------
`ifndef RAY_MARCH_BOX_PROBE_CORE_MACROS_SVH
`define RAY_MARCH_BOX_PROBE_CORE_MACROS_SVH

// same-cycle implication
`define RMBP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMBP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rmbp_pkg.sv =====
// ---------------------------------------------------------------------------
// rmbp_pkg
// Shared types and constants of the ray march box probe.
// ---------------------------------------------------------------------------
package rmbp_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // one unit of slack in Q12.4
  localparam int TOLERANCE = 16;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic        [14:0] hw;
    logic        [14:0] hh;
  } box_t;

  typedef struct packed {
    logic       load;      // latch query operands, init divider
    logic       wr_en;     // box table write
    logic       div_step;  // one quotient bit
    logic       div_fix;   // apply sign to step vector
    logic       advance;   // move probe point one step
    logic       finish;    // register result
    logic       found;
    logic [3:0] slot;
    logic [4:0] rd_idx;    // box table read index
  } cmd_t;

  typedef struct packed {
    logic       box_hit;
    logic       step_zero;
    logic [7:0] steps;
    logic [4:0] count;
  } sts_t;

endpackage

// ===== design/ray_march_box_probe_core.sv =====
// ---------------------------------------------------------------------------
// ray_march_box_probe_core
// Marches a probe point from start toward dest and reports the first box hit.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with the request fields; the request is taken on a rising
//   edge where start is high and busy is low.
//   opcode = write: stores one box entry in that cycle; busy stays low and no
//   result follows. Slots at or above BOX_SLOTS are dropped.
//   opcode = query: busy rises for the whole march. A query with a step count
//   of zero is taken and ignored. Otherwise one result follows: done pulses
//   for exactly one cycle with hit, hit_slot, final_x/y and safe_x/y. The
//   receiver cannot stall; done is not held.
//   Query time grows with the steps marched (the march stops at the first
//   hit) and the boxes tested per step; it is set by the serial step divider
//   and one box table read and test per cycle.
//   Reset: busy and done drop, the safe point clears to zero; box table
//   contents stay undefined until written.
// ---------------------------------------------------------------------------
module ray_march_box_probe_core
  import rmbp_pkg::*;
#(
  parameter int BOX_SLOTS = 16,
  parameter int MAX_STEPS = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic        [3:0]  box_slot,
  input  logic signed [15:0] box_center_x,
  input  logic signed [15:0] box_center_y,
  input  logic        [14:0] box_half_w,
  input  logic        [14:0] box_half_h,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] dest_x,
  input  logic signed [15:0] dest_y,
  input  logic        [7:0]  step_total,
  input  logic        [4:0]  boxes_in_use,
  output logic               done,
  output logic               hit,
  output logic        [3:0]  hit_slot,
  output logic signed [15:0] final_x,
  output logic signed [15:0] final_y,
  output logic signed [15:0] safe_x,
  output logic signed [15:0] safe_y
);

  cmd_t cmd;
  sts_t sts;

  rmbp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  rmbp_datapath #(
    .BOX_SLOTS (BOX_SLOTS),
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .box_slot     (box_slot),
    .box_center_x (box_center_x),
    .box_center_y (box_center_y),
    .box_half_w   (box_half_w),
    .box_half_h   (box_half_h),
    .start_x      (start_x),
    .start_y      (start_y),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .step_total   (step_total),
    .boxes_in_use (boxes_in_use),
    .done         (done),
    .hit          (hit),
    .hit_slot     (hit_slot),
    .final_x      (final_x),
    .final_y      (final_y),
    .safe_x       (safe_x),
    .safe_y       (safe_y)
  );

endmodule

// ===== design/rmbp_ctrl.sv =====
// ---------------------------------------------------------------------------
// rmbp_ctrl
// Sequencer: divide, then march steps, testing one box per cycle.
// ---------------------------------------------------------------------------
`include "ray_march_box_probe_core_macros.svh"

module rmbp_ctrl
  import rmbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic opcode,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_STEP,
    S_TEST,
    S_OUT
  } state_t;

  state_t     state;
  logic [3:0] div_cnt;
  logic [7:0] step_cnt;
  logic [4:0] box_idx;
  logic       found;
  logic [3:0] slot;
  logic       go;

  assign busy = (state != S_IDLE);
  assign go   = start && !busy && (opcode == OP_QUERY) && !sts.step_zero;

  always_comb begin
    cmd          = '0;
    cmd.load     = go;
    cmd.wr_en    = start && !busy && (opcode == OP_WRITE);
    cmd.div_step = (state == S_DIV);
    cmd.div_fix  = (state == S_FIX);
    cmd.advance  = (state == S_STEP);
    cmd.finish   = (state == S_OUT);
    cmd.found    = found;
    cmd.slot     = slot;
    cmd.rd_idx   = (state == S_TEST) ? box_idx + 5'd1 : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      div_cnt  <= '0;
      step_cnt <= '0;
      box_idx  <= '0;
      found    <= 1'b0;
      slot     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            state   <= S_DIV;
            div_cnt <= '0;
            found   <= 1'b0;
            slot    <= '0;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'hF) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          step_cnt <= '0;
          state    <= S_STEP;
        end
        S_STEP: begin
          step_cnt <= step_cnt + 8'd1;
          box_idx  <= '0;
          if (sts.count != 5'd0) begin
            state <= S_TEST;
          end else if ({1'b0, step_cnt} + 9'd1 == {1'b0, sts.steps}) begin
            state <= S_OUT;
          end
        end
        S_TEST: begin
          if (sts.box_hit) begin
            found <= 1'b1;
            slot  <= box_idx[3:0];
            state <= S_OUT;
          end else if (box_idx + 5'd1 == sts.count) begin
            state <= (step_cnt == sts.steps) ? S_OUT : S_STEP;
          end else begin
            box_idx <= box_idx + 5'd1;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RMBP_ASSERT_NEXT(a_query_starts_div, go, state == S_DIV, "query accepted without divide")
  `RMBP_ASSERT_NEXT(a_div_ends_in_fix, state == S_DIV && div_cnt == 4'hF, state == S_FIX, "divider ran past 16 bits")
  `RMBP_ASSERT_NOW(a_box_in_range, state == S_TEST, box_idx < sts.count, "box index beyond box count")
  `RMBP_ASSERT_NOW(a_out_after_step, state == S_OUT, step_cnt != 8'd0, "result before any step")

endmodule

// ===== design/rmbp_datapath.sv =====
// ---------------------------------------------------------------------------
// rmbp_datapath
// Box table, serial step divider, probe point, box test and result registers.
// ---------------------------------------------------------------------------
module rmbp_datapath
  import rmbp_pkg::*;
#(
  parameter int BOX_SLOTS = 16,
  parameter int MAX_STEPS = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic        [3:0]  box_slot,
  input  logic signed [15:0] box_center_x,
  input  logic signed [15:0] box_center_y,
  input  logic        [14:0] box_half_w,
  input  logic        [14:0] box_half_h,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] dest_x,
  input  logic signed [15:0] dest_y,
  input  logic        [7:0]  step_total,
  input  logic        [4:0]  boxes_in_use,
  output logic               done,
  output logic               hit,
  output logic        [3:0]  hit_slot,
  output logic signed [15:0] final_x,
  output logic signed [15:0] final_y,
  output logic signed [15:0] safe_x,
  output logic signed [15:0] safe_y
);

  localparam int         SLOT_W  = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
  localparam logic [8:0] SLOTS9  = 9'(BOX_SLOTS);
  localparam logic [11:0] STEPS12 = 12'(MAX_STEPS);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  box_t              mem [BOX_SLOTS];
  box_t              rd_q;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic              slot_ok;

  logic [7:0]  steps;
  logic [4:0]  count;
  logic [7:0]  steps_in;
  logic [4:0]  count_in;

  logic signed [16:0] diff_x, diff_y;
  logic        [16:0] mag_x, mag_y;
  logic        [15:0] dvd_x, dvd_y;
  logic        [7:0]  rem_x, rem_y;
  logic               neg_x, neg_y;
  logic        [9:0]  trial_x, trial_y;

  logic signed [16:0] sx, sy;
  logic signed [17:0] px, py, prev_x, prev_y;
  logic signed [15:0] safe_pt_x, safe_pt_y;

  logic signed [18:0] dx, dy;
  logic        [18:0] ax, ay, lim_x, lim_y;

  // ---- box table ----
  assign wr_addr = SLOT_W'(box_slot);
  assign rd_addr = SLOT_W'(cmd.rd_idx);
  assign slot_ok = ({5'd0, box_slot} < SLOTS9);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      mem[wr_addr] <= '{cx: box_center_x, cy: box_center_y,
                        hw: box_half_w, hh: box_half_h};
    end
    rd_q <= mem[rd_addr];
  end

  // ---- operand limits ----
  always_comb begin
    steps_in = ({4'd0, step_total} > STEPS12) ? 8'(MAX_STEPS) : step_total;
    count_in = ({4'd0, boxes_in_use} > SLOTS9) ? 5'(BOX_SLOTS) : boxes_in_use;
  end

  assign diff_x = 17'(dest_x) - 17'(start_x);
  assign diff_y = 17'(dest_y) - 17'(start_y);
  assign mag_x  = diff_x[16] ? 17'd0 - 17'(diff_x) : 17'(diff_x);
  assign mag_y  = diff_y[16] ? 17'd0 - 17'(diff_y) : 17'(diff_y);

  // restoring division, one quotient bit per cycle; quotient shifts into dvd
  assign trial_x = {1'b0, rem_x, dvd_x[15]} - {2'b00, steps};
  assign trial_y = {1'b0, rem_y, dvd_y[15]} - {2'b00, steps};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps  <= steps_in;
      count  <= count_in;
      dvd_x  <= mag_x[15:0];
      dvd_y  <= mag_y[15:0];
      neg_x  <= diff_x[16];
      neg_y  <= diff_y[16];
      rem_x  <= '0;
      rem_y  <= '0;
      px     <= 18'(start_x);
      py     <= 18'(start_y);
      prev_x <= 18'(start_x);
      prev_y <= 18'(start_y);
    end
    if (cmd.div_step) begin
      if (!trial_x[9]) begin
        rem_x <= trial_x[7:0];
        dvd_x <= {dvd_x[14:0], 1'b1};
      end else begin
        rem_x <= {rem_x[6:0], dvd_x[15]};
        dvd_x <= {dvd_x[14:0], 1'b0};
      end
      if (!trial_y[9]) begin
        rem_y <= trial_y[7:0];
        dvd_y <= {dvd_y[14:0], 1'b1};
      end else begin
        rem_y <= {rem_y[6:0], dvd_y[15]};
        dvd_y <= {dvd_y[14:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      sx <= neg_x ? -$signed({1'b0, dvd_x}) : $signed({1'b0, dvd_x});
      sy <= neg_y ? -$signed({1'b0, dvd_y}) : $signed({1'b0, dvd_y});
    end
    if (cmd.advance) begin
      prev_x <= px;
      prev_y <= py;
      px     <= px + 18'(sx);
      py     <= py + 18'(sy);
    end
  end

  // ---- box test on the registered table entry ----
  always_comb begin
    dx    = 19'($signed(rd_q.cx)) - 19'(px);
    dy    = 19'($signed(rd_q.cy)) - 19'(py);
    ax    = dx[18] ? 19'd0 - 19'(dx) : 19'(dx);
    ay    = dy[18] ? 19'd0 - 19'(dy) : 19'(dy);
    lim_x = 19'(rd_q.hw) + 19'(TOLERANCE);
    lim_y = 19'(rd_q.hh) + 19'(TOLERANCE);
  end

  assign sts.box_hit   = (ax <= lim_x) && (ay <= lim_y);
  assign sts.step_zero = (step_total == 8'd0);
  assign sts.steps     = steps;
  assign sts.count     = count;

  // ---- safe point and results ----
  always_ff @(posedge clk) begin
    if (rst) begin
      safe_pt_x <= '0;
      safe_pt_y <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish && cmd.found) begin
        safe_pt_x <= sat16(prev_x);
        safe_pt_y <= sat16(prev_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit      <= cmd.found;
      hit_slot <= cmd.slot;
      final_x  <= sat16(px);
      final_y  <= sat16(py);
      safe_x   <= cmd.found ? sat16(prev_x) : safe_pt_x;
      safe_y   <= cmd.found ? sat16(prev_y) : safe_pt_y;
    end
  end

endmodule
